// ===== rtl/drd_pkg.sv =====
`default_nettype none

package drd_pkg;

    // Fixed field widths
    localparam int VAL_W   = 24;
    localparam int CLASS_W = 7;
    localparam int SCALE_W = 16;
    localparam int OUT_W   = 28;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 4;

    // Corner offset 2*c - w, and the widest product of an offset and a scale
    localparam int DX_W   = VAL_W + 2;
    localparam int PROD_W = DX_W + SCALE_W + 1;

    localparam int GEOMETRY_COUNT   = 4;
    localparam int MAX_CLASSES_DEF  = 128;

    // Positions of the geometry values within a row
    localparam int POS_CENTRE_X = 0;
    localparam int POS_CENTRE_Y = 1;
    localparam int POS_WIDTH    = 2;
    localparam int POS_HEIGHT   = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_CLASS_COUNT     = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SCORE_THRESHOLD = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_SCALE_X         = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SCALE_Y         = IDX_W'(3);

    // Reset values of the configuration registers
    localparam logic [7:0]         RST_CLASS_COUNT     = 8'd80;
    localparam logic [VAL_W-1:0]   RST_SCORE_THRESHOLD = VAL_W'(2048);
    localparam logic [SCALE_W-1:0] RST_SCALE           = SCALE_W'(4096);

    // One finished row on its way to the scaling pipeline
    typedef struct packed {
        logic signed [DX_W-1:0]  dx;
        logic signed [DX_W-1:0]  dy;
        logic signed [VAL_W-1:0] w;
        logic signed [VAL_W-1:0] h;
        logic [SCALE_W-1:0]      sx;
        logic [SCALE_W-1:0]      sy;
        logic [CLASS_W-1:0]      cls;
    } drd_job_t;

    // Round to nearest (halves up) by 2^13 or 2^12, then clamp to the output range
    function automatic logic signed [OUT_W-1:0] drd_round_sat(
        input logic signed [PROD_W-1:0] p,
        input logic                     shift13
    );
        logic signed [PROD_W:0] t;
        logic signed [PROD_W:0] hi;
        logic signed [PROD_W:0] lo;
        hi = (PROD_W+1)'((1 << (OUT_W-1)) - 1);
        lo = ~hi;
        if (shift13) begin
            t = {p[PROD_W-1], p} + (PROD_W+1)'(1 << 12);
            t = t >>> 13;
        end else begin
            t = {p[PROD_W-1], p} + (PROD_W+1)'(1 << 11);
            t = t >>> 12;
        end
        if (t > hi) begin
            return hi[OUT_W-1:0];
        end else if (t < lo) begin
            return lo[OUT_W-1:0];
        end else begin
            return t[OUT_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/drd_box_scale.sv =====
`default_nettype none

module drd_box_scale
    import drd_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire drd_job_t                 in_job,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [OUT_W-1:0]       m_box_x,
    output logic signed [OUT_W-1:0]       m_box_y,
    output logic signed [OUT_W-1:0]       m_box_w,
    output logic signed [OUT_W-1:0]       m_box_h,
    output logic [CLASS_W-1:0]            m_label
);

    drd_job_t                  job_reg;
    logic                      job_valid_reg;
    logic signed [PROD_W-1:0]  px_reg, py_reg, pw_reg, ph_reg;
    logic signed [PROD_W-1:0]  px_next, py_next, pw_next, ph_next;
    logic [CLASS_W-1:0]        pcls_reg;
    logic                      prod_valid_reg;
    logic signed [OUT_W-1:0]   bx_reg, by_reg, bw_reg, bh_reg;
    logic [CLASS_W-1:0]        ocls_reg;
    logic                      out_valid_reg;
    logic                      out_adv, prod_adv;

    // Each stage moves on when it is empty or its successor moves on
    assign out_adv  = !out_valid_reg || m_ready;
    assign prod_adv = !prod_valid_reg || out_adv;
    assign in_ready = !job_valid_reg || prod_adv;

    always_comb begin
        px_next = PROD_W'($signed(job_reg.dx)) * PROD_W'($signed({1'b0, job_reg.sx}));
        py_next = PROD_W'($signed(job_reg.dy)) * PROD_W'($signed({1'b0, job_reg.sy}));
        pw_next = PROD_W'($signed(job_reg.w)) * PROD_W'($signed({1'b0, job_reg.sx}));
        ph_next = PROD_W'($signed(job_reg.h)) * PROD_W'($signed({1'b0, job_reg.sy}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_ready) begin
                job_valid_reg <= in_valid;
            end
            if (prod_adv) begin
                prod_valid_reg <= job_valid_reg;
            end
            if (out_adv) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            job_reg <= in_job;
        end
        if (prod_adv) begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pw_reg   <= pw_next;
            ph_reg   <= ph_next;
            pcls_reg <= job_reg.cls;
        end
        if (out_adv) begin
            bx_reg   <= drd_round_sat(px_reg, 1'b1);
            by_reg   <= drd_round_sat(py_reg, 1'b1);
            bw_reg   <= drd_round_sat(pw_reg, 1'b0);
            bh_reg   <= drd_round_sat(ph_reg, 1'b0);
            ocls_reg <= pcls_reg;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_box_x    = bx_reg;
    assign m_box_y    = by_reg;
    assign m_box_w    = bw_reg;
    assign m_box_h    = bh_reg;
    assign m_label    = ocls_reg;

endmodule

`default_nettype wire

// ===== rtl/detection_row_decode.sv =====
// Detection row decoder.
// Input channel (s_valid/s_ready/s_feature_value): one Q11.12 tensor value per
// word, rows laid out as centre x, centre y, width, height and then
// class_count scores. The block counts its own place in the row.
// Result channel (m_valid/m_ready/m_box_*/m_label): one box per row whose
// best score is strictly above score_threshold; rows that fail emit nothing.
// Configuration (cfg_wr_en/cfg_index/cfg_data): single-cycle writes, to be
// issued only while no box is in flight.
// Throughput: one word per cycle while s_ready stays high, including the row's last score.
// Pipeline: the edge that takes a row's last score loads its box into the first
// of three registers: a job register, a product register holding the four scale
// multiplies, and the output register after rounding and clamping.
// Stalls: each stage advances independently, so words keep flowing while a
// box waits on m_ready until the job and product stages are full as well;
// only then does s_ready fall.
// Reset: synchronous and active low; the row position returns to the start,
// the pipeline empties and the configuration registers take their default values.

`default_nettype none

module detection_row_decode
    import drd_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [VAL_W-1:0]  s_feature_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [OUT_W-1:0]       m_box_x,
    output logic signed [OUT_W-1:0]       m_box_y,
    output logic signed [OUT_W-1:0]       m_box_w,
    output logic signed [OUT_W-1:0]       m_box_h,
    output logic [CLASS_W-1:0]            m_label,
    input  wire logic                     cfg_wr_en,
    input  wire logic [IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]         cfg_data
);

    // The count register is eight bits wide, so no row holds more than 255 scores
    localparam int LIMIT = (MAX_CLASSES < 255) ? MAX_CLASSES : 255;
    localparam int POS_W = $clog2(GEOMETRY_COUNT + LIMIT);

    // Configuration registers
    logic [7:0]                class_count_reg;
    logic signed [VAL_W-1:0]   threshold_reg;
    logic [SCALE_W-1:0]        scale_x_reg;
    logic [SCALE_W-1:0]        scale_y_reg;

    // Row state
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic signed [VAL_W-1:0]   cx_reg, cy_reg, w_reg, h_reg;
    logic signed [VAL_W-1:0]   best_reg, best_next;
    logic [CLASS_W-1:0]        cls_reg, cls_next;

    logic [7:0]                n_eff;
    logic [POS_W-1:0]          last_pos;
    logic                      is_geom, is_last, take, emit, accept;
    logic                      job_valid;
    drd_job_t                  job;

    assign accept = s_valid && s_ready;

    // Clamp the class count into 1..LIMIT and find the last score's position
    always_comb begin
        if (class_count_reg == 8'd0) begin
            n_eff = 8'd1;
        end else if (class_count_reg > 8'(LIMIT)) begin
            n_eff = 8'(LIMIT);
        end else begin
            n_eff = class_count_reg;
        end
        last_pos = POS_W'(GEOMETRY_COUNT - 1) + POS_W'(n_eff);
    end

    // Score tracking: the first score always loads, later ones only if strictly greater
    always_comb begin
        is_geom   = pos_reg < POS_W'(GEOMETRY_COUNT);
        // A count cut mid-row makes the current word the last score
        is_last   = !is_geom && (pos_reg >= last_pos);
        take      = (pos_reg == POS_W'(GEOMETRY_COUNT)) || (s_feature_value > best_reg);
        best_next = take ? s_feature_value : best_reg;
        cls_next  = take ? CLASS_W'(pos_reg - POS_W'(GEOMETRY_COUNT)) : cls_reg;
        emit      = is_last && (best_next > threshold_reg);
        pos_next  = is_last ? '0 : pos_reg + POS_W'(1);
    end

    // Corner offsets in Q.13: 2*c - w is c - w/2 with one more fraction bit
    always_comb begin
        job.dx  = {cx_reg[VAL_W-1], cx_reg, 1'b0} - {{2{w_reg[VAL_W-1]}}, w_reg};
        job.dy  = {cy_reg[VAL_W-1], cy_reg, 1'b0} - {{2{h_reg[VAL_W-1]}}, h_reg};
        job.w   = w_reg;
        job.h   = h_reg;
        job.sx  = scale_x_reg;
        job.sy  = scale_y_reg;
        job.cls = cls_next;
    end

    assign job_valid = s_valid && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            class_count_reg <= RST_CLASS_COUNT;
            threshold_reg   <= RST_SCORE_THRESHOLD;
            scale_x_reg     <= RST_SCALE;
            scale_y_reg     <= RST_SCALE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CLASS_COUNT:     class_count_reg <= cfg_data[7:0];
                REG_SCORE_THRESHOLD: threshold_reg   <= cfg_data[VAL_W-1:0];
                REG_SCALE_X:         scale_x_reg     <= cfg_data[SCALE_W-1:0];
                REG_SCALE_Y:         scale_y_reg     <= cfg_data[SCALE_W-1:0];
                default:             ; // drop writes to unknown indexes
            endcase
        end
    end

    // Advance the row position on every accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
        end
    end

    // Hold geometry values and the running best score
    always_ff @(posedge aclk) begin
        if (accept) begin
            case (pos_reg)
                POS_W'(POS_CENTRE_X): cx_reg <= s_feature_value;
                POS_W'(POS_CENTRE_Y): cy_reg <= s_feature_value;
                POS_W'(POS_WIDTH):    w_reg  <= s_feature_value;
                POS_W'(POS_HEIGHT):   h_reg  <= s_feature_value;
                default: begin
                    best_reg <= best_next;
                    cls_reg  <= cls_next;
                end
            endcase
        end
    end

    drd_box_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (job_valid),
        .in_ready   (s_ready),
        .in_job     (job),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_box_x    (m_box_x),
        .m_box_y    (m_box_y),
        .m_box_w    (m_box_w),
        .m_box_h    (m_box_h),
        .m_label    (m_label)
    );

`ifndef SYNTH
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(GEOMETRY_COUNT + LIMIT - 1))
        else $error("row position beyond the longest row");

    a_geom_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_geom |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("geometry word did not advance the row position");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> $stable(pos_reg) && $stable(best_reg))
        else $error("row state changed on a refused word");
`endif

endmodule

`default_nettype wire
